### design/occp_pkg.sv
// Shared types and constants for the operator console command parser.
package occp_pkg;

    // Widths of the buffered argument state, addresses and characters.
    localparam int unsigned OCTAL_W = 31;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned CHAR_W  = 8;

    // Stream payload widths, padded to whole bytes.
    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 48;

    // Console characters with a meaning of their own.
    localparam logic [CHAR_W-1:0] CH_NL       = 8'd10;
    localparam logic [CHAR_W-1:0] CH_ESC      = 8'd27;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BANG     = 8'h21;
    localparam logic [CHAR_W-1:0] CH_HASH     = 8'h23;
    localparam logic [CHAR_W-1:0] CH_DOLLAR   = 8'h24;
    localparam logic [CHAR_W-1:0] CH_AMP      = 8'h26;
    localparam logic [CHAR_W-1:0] CH_STAR     = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DOT      = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SLASH    = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SEVEN    = 8'h37;
    localparam logic [CHAR_W-1:0] CH_LT       = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_QUESTION = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_AT       = 8'h40;
    localparam logic [CHAR_W-1:0] CH_A        = 8'h41;
    localparam logic [CHAR_W-1:0] CH_Y        = 8'h59;
    localparam logic [CHAR_W-1:0] CH_Z        = 8'h5A;

    // Largest value that still fits a breakpoint address.
    localparam logic [ADDR_W-1:0] ADDR_ALL_ONES = 16'hFFFF;

    // Mode request codes.
    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_BREAK = 2'd1,
        MODE_RUN   = 2'd2
    } t_mode;

    // Buffered argument held between characters.
    typedef struct packed {
        logic [OCTAL_W-1:0] octal_value;
        logic [COUNT_W-1:0] char_count;
        logic               letter_seen;
        logic               too_large;
    } t_buf_state;

    // One result item.
    typedef struct packed {
        logic              echo_valid;
        logic [CHAR_W-1:0] echo_char;
        logic              breakpoint_set;
        logic [ADDR_W-1:0] breakpoint_addr;
        logic              pc_load;
        logic [ADDR_W-1:0] pc_value;
        t_mode             mode_request;
    } t_result;

endpackage

### design/occp_decode.sv
// Character classifier and argument buffer update for one console character.
module occp_decode import occp_pkg::*; #(
    parameter int unsigned BUFFER_CHARS = 255
) (
    input  logic [CHAR_W-1:0] i_char,
    input  logic              i_stopped,
    input  t_buf_state        i_state,
    output t_buf_state        o_state,
    output t_result           o_result
);

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(BUFFER_CHARS);

    logic                 is_digit;
    logic                 is_letter;
    logic                 is_clear;
    logic                 is_echo_only;
    logic                 buf_room;
    logic                 arg_valid;
    logic                 buf_empty;
    logic [OCTAL_W+2:0]   shifted;

    // Classify the character.
    assign is_digit     = (i_char >= CH_ZERO) && (i_char <= CH_SEVEN);
    assign is_letter    = (i_char >= CH_A) && (i_char <= CH_Y);
    assign is_clear     = (i_char == CH_AT) || (i_char == CH_SPACE) || (i_char == CH_NL);
    assign is_echo_only = (i_char == CH_LT) || (i_char == CH_SLASH) ||
                          (i_char == CH_STAR) || (i_char == CH_AMP) ||
                          (i_char == CH_DOLLAR) || (i_char == CH_Z) ||
                          (i_char == CH_HASH);

    assign buf_room  = i_state.char_count < COUNT_MAX;
    assign arg_valid = !i_state.letter_seen && !i_state.too_large;
    assign buf_empty = i_state.char_count == '0;

    // Accumulator shifted by one octal digit, with the new digit added.
    assign shifted = {i_state.octal_value, 3'b000} + (OCTAL_W+3)'(i_char[2:0]);

    // Next buffer state and result.
    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.echo_valid   = 1'b1;
        o_result.echo_char    = i_char;
        o_result.mode_request = MODE_NONE;

        if (is_digit || is_letter) begin
            if (buf_room) begin
                o_state.char_count = i_state.char_count + COUNT_W'(1);
                if (is_digit) begin
                    if (!i_state.too_large) begin
                        // Anything above 31 bits marks the argument too large.
                        if (shifted[OCTAL_W+2:OCTAL_W] != 3'b000) begin
                            o_state.too_large = 1'b1;
                        end else begin
                            o_state.octal_value = shifted[OCTAL_W-1:0];
                        end
                    end
                end else begin
                    o_state.letter_seen = 1'b1;
                end
            end
        end else if (is_clear) begin
            o_state = '0;
        end else if (is_echo_only) begin
            o_state = i_state;
        end else if (i_char == CH_DOT) begin
            // A breakpoint needs a valid, non-empty argument below 64K.
            if (!buf_empty && arg_valid &&
                (i_state.octal_value[OCTAL_W-1:ADDR_W] == '0)) begin
                o_result.breakpoint_set  = 1'b1;
                o_result.breakpoint_addr = i_state.octal_value[ADDR_W-1:0];
                o_result.mode_request    = MODE_BREAK;
            end
            o_state = '0;
        end else if (i_char == CH_BANG) begin
            if (i_stopped) begin
                if (!buf_empty) begin
                    o_result.pc_load  = 1'b1;
                    o_result.pc_value = arg_valid ? i_state.octal_value[ADDR_W-1:0]
                                                  : ADDR_ALL_ONES;
                end
                o_result.mode_request = MODE_RUN;
            end else begin
                o_result.echo_char = CH_QUESTION;
            end
        end else if (i_char == CH_ESC) begin
            o_result.echo_valid = 1'b0;
            o_result.echo_char  = '0;
        end else begin
            o_result.echo_char = CH_QUESTION;
        end
    end

endmodule

### design/operator_console_command_parser.sv
// Top level of the operator console command parser: stream ports and registers.
//
// Usage: each transfer on the slave stream carries one console character and
// the CPU stop flag. Each accepted character yields exactly one result on the
// master stream: the echo (or none for ESC, '?' for errors), a breakpoint
// address with a breakpoint-mode request on '.' after a valid argument, and a
// run request, with a PC load if an argument is held, on '!' while the CPU is
// stopped. Octal digits and letters are kept in an argument buffer between
// characters. An accepted character waits in the input register until the
// result register can take its result; the decode step then works on it and
// its result is registered. Throughput is one character per cycle while the
// receiver does not stall, set by the single decode step between the input
// and result registers that also updates the argument buffer.
// Reset clears the valid flags of both stream registers and the argument buffer.
// When the receiver stalls, the result stays in the output register and one
// more character is held in the input register; only then does o_s_tready
// drop, and it rises again in the cycle the receiver takes the result.
module operator_console_command_parser import occp_pkg::*; #(
    parameter int unsigned BUFFER_CHARS = 255
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // Bits from the lowest: char_in[7:0], cpu_halted[8], zero[15:9].
    input  logic [S_DATA_W-1:0] i_s_tdata,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // Bits from the lowest: echo_valid[0], echo_char[8:1], breakpoint_set[9],
    // breakpoint_addr[25:10], pc_load[26], pc_value[42:27],
    // mode_request[44:43], zero[47:45].
    output logic [M_DATA_W-1:0] o_m_tdata
);

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_stopped;
    logic              r_out_valid;
    t_result           r_out;
    t_buf_state        r_buf;
    t_buf_state        n_buf;
    t_result           n_out;
    logic              step;

    // Decode the held character whenever the result register can take it.
    assign step       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || step;

    occp_decode #(
        .BUFFER_CHARS (BUFFER_CHARS)
    ) u_decode (
        .i_char    (r_in_char),
        .i_stopped (r_in_stopped),
        .i_state   (r_buf),
        .o_state   (n_buf),
        .o_result  (n_out)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char    <= i_s_tdata[CHAR_W-1:0];
            r_in_stopped <= i_s_tdata[CHAR_W];
        end
    end

    // Argument buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0;
        end else if (step) begin
            r_buf <= n_buf;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out.mode_request, r_out.pc_value, r_out.pc_load,
                         r_out.breakpoint_addr, r_out.breakpoint_set,
                         r_out.echo_char, r_out.echo_valid};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buf.char_count <= COUNT_W'(BUFFER_CHARS))
        else $error("argument buffer count above its limit");

    a_letter_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buf.letter_seen |-> (r_buf.char_count != '0))
        else $error("letter flag set with an empty buffer");

    a_large_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buf.too_large |-> (r_buf.char_count != '0))
        else $error("overflow flag set with an empty buffer");

    a_bp_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.breakpoint_set == (r_out.mode_request == MODE_BREAK)))
        else $error("breakpoint set and breakpoint-mode request disagree");

    a_pc_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.pc_load) |-> (r_out.mode_request == MODE_RUN))
        else $error("PC load without a run request");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed or lost");
`endif

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the operator console command parser stream block.
module testbench;
    import occp_pkg::*;

    localparam int unsigned BUFFER_CHARS = 255;
    localparam int          TOTAL_KEYS   = 1600;
    localparam int          CYCLE_LIMIT  = 500000;
    localparam logic [63:0] INT_MAX      = 64'h7FFF_FFFF;
    localparam logic [31:0] ADDR_SPAN    = 32'd65536;

    // One console keystroke as queued for the driver.
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              stopped;
        bit                drain_first;
    } t_console_key;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    // Bits from the lowest: char_in[7:0], cpu_halted[8], zero[15:9].
    logic [S_DATA_W-1:0] i_s_tdata = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    // Bits from the lowest: echo_valid[0], echo_char[8:1], breakpoint_set[9],
    // breakpoint_addr[25:10], pc_load[26], pc_value[42:27], mode_request[44:43].
    logic [M_DATA_W-1:0] o_m_tdata;

    t_console_key pending_keys[$];
    t_result      expected_results[$];
    int           queued_total = 0;
    int           keys_sent = 0;
    int           results_seen = 0;
    int           error_count = 0;
    int           cycle_count = 0;

    // Predicted argument buffer of the parser.
    logic [31:0]  acc_value;
    int unsigned  held_chars;
    logic         has_letter;
    logic         overflowed;

    operator_console_command_parser #(
        .BUFFER_CHARS(BUFFER_CHARS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_argument();
        acc_value  = '0;
        held_chars = 0;
        has_letter = 1'b0;
        overflowed = 1'b0;
    endfunction

    // Works out the result of one keystroke and advances the predicted buffer.
    function automatic t_result decode_console_char(logic [CHAR_W-1:0] ch, logic stopped);
        t_result     r;
        logic [63:0] grown;
        logic        arg_ok;
        r = '0;
        r.echo_valid   = 1'b1;
        r.echo_char    = ch;
        r.mode_request = MODE_NONE;
        arg_ok = !has_letter && !overflowed;
        if ((ch >= CH_ZERO && ch <= CH_SEVEN) || (ch >= CH_A && ch <= CH_Y)) begin
            // Buffer characters are dropped once the buffer is full.
            if (held_chars < BUFFER_CHARS) begin
                held_chars++;
                if (ch <= CH_SEVEN) begin
                    grown = {32'd0, acc_value} * 64'd8 + 64'(ch - CH_ZERO);
                    if (!overflowed) begin
                        if (grown > INT_MAX) begin
                            overflowed = 1'b1;
                        end else begin
                            acc_value = grown[31:0];
                        end
                    end
                end else begin
                    has_letter = 1'b1;
                end
            end
        end else if (ch == CH_AT || ch == CH_SPACE || ch == CH_NL) begin
            clear_argument();
        end else if (ch == CH_LT || ch == CH_SLASH || ch == CH_STAR || ch == CH_AMP ||
                     ch == CH_DOLLAR || ch == CH_Z || ch == CH_HASH) begin
            // Echoed and nothing more.
        end else if (ch == CH_DOT) begin
            if (held_chars != 0 && arg_ok && acc_value < ADDR_SPAN) begin
                r.breakpoint_set  = 1'b1;
                r.breakpoint_addr = acc_value[ADDR_W-1:0];
                r.mode_request    = MODE_BREAK;
            end
            clear_argument();
        end else if (ch == CH_BANG) begin
            if (stopped) begin
                if (held_chars != 0) begin
                    r.pc_load  = 1'b1;
                    r.pc_value = arg_ok ? acc_value[ADDR_W-1:0] : ADDR_ALL_ONES;
                end
                r.mode_request = MODE_RUN;
            end else begin
                r.echo_char = CH_QUESTION;
            end
        end else if (ch == CH_ESC) begin
            r.echo_valid = 1'b0;
            r.echo_char  = '0;
        end else begin
            r.echo_char = CH_QUESTION;
        end
        return r;
    endfunction

    task automatic put_key(logic [CHAR_W-1:0] ch, logic stopped, bit drain_first = 0);
        t_console_key k;
        k.ch          = ch;
        k.stopped     = stopped;
        k.drain_first = drain_first;
        pending_keys.push_back(k);
        queued_total++;
    endtask

    task automatic put_text(string s, logic stopped);
        for (int i = 0; i < s.len(); i++) begin
            put_key(s[i], stopped);
        end
    endtask

    // Types a value in octal, sometimes with leading zeros.
    task automatic put_octal(logic [31:0] v);
        logic [CHAR_W-1:0] digits[$];
        int                pad;
        pad = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
        do begin
            digits.push_front(CH_ZERO + 8'(v[2:0]));
            v = v >> 3;
        end while (v != 0);
        repeat (pad) digits.push_front(CH_ZERO);
        foreach (digits[i]) put_key(digits[i], 1'($urandom_range(0, 1)));
    endtask

    function automatic logic [CHAR_W-1:0] random_echo_only();
        logic [CHAR_W-1:0] picks[8];
        picks = '{CH_LT, CH_SLASH, CH_STAR, CH_AMP, CH_DOLLAR, CH_Z, CH_HASH, CH_ESC};
        return picks[$urandom_range(0, 7)];
    endfunction

    function automatic logic [CHAR_W-1:0] random_buffer_char();
        if ($urandom_range(0, 3) == 0) return CH_A + 8'($urandom_range(0, 24));
        return CH_ZERO + 8'($urandom_range(0, 7));
    endfunction

    // Queues one console command: an optional clear, an argument and an optional terminator.
    task automatic put_command(int idx);
        int                kind;
        logic [31:0]       v;
        logic [CHAR_W-1:0] clears[3];
        logic [31:0]       edges[6];
        clears = '{CH_AT, CH_SPACE, CH_NL};
        edges  = '{32'd0, 32'h0000_FFFF, 32'h0001_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'hFFFF_FFFF};
        if ($urandom_range(0, 3) == 0) begin
            put_key(clears[$urandom_range(0, 2)], 1'($urandom_range(0, 1)),
                    idx == 0 || $urandom_range(0, 49) == 0);
        end else if (idx == 0 || $urandom_range(0, 49) == 0) begin
            put_key(clears[$urandom_range(0, 2)], 1'($urandom_range(0, 1)), 1);
        end
        kind = (idx % 90 == 45) ? 10 : $urandom_range(0, 9);
        case (kind)
            0, 1, 2: put_octal($urandom_range(0, 32'h1FFFF));
            3: put_octal(edges[$urandom_range(0, 5)]);
            4: repeat ($urandom_range(9, 14)) put_key(CH_ZERO + 8'($urandom_range(0, 7)), 1'b0);
            5: repeat ($urandom_range(1, 6)) put_key(random_buffer_char(), 1'($urandom_range(0, 1)));
            6: ;
            7: repeat ($urandom_range(1, 5)) put_key(8'($urandom_range(0, 255)),
                                                  1'($urandom_range(0, 1)));
            8: repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 1)) put_key(random_echo_only(), 1'($urandom_range(0, 1)));
                else put_key(CH_ZERO + 8'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            end
            9: repeat ($urandom_range(1, 8)) put_key(CH_ZERO + 8'($urandom_range(0, 7)), 1'b1);
            default: begin
                // Fill the buffer up to or past its end; any extra characters are dropped.
                repeat (250) put_key(CH_ZERO, 1'($urandom_range(0, 1)));
                repeat (3) put_key(CH_ZERO + 8'($urandom_range(0, 7)), 1'b0);
                repeat ($urandom_range(2, 8)) put_key(random_buffer_char(), 1'b0);
            end
        endcase
        if (kind != 7) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: put_key(CH_DOT, 1'($urandom_range(0, 1)));
                4, 5, 6, 7, 8: put_key(CH_BANG, 1'($urandom_range(0, 3) != 0));
                default: ;
            endcase
        end
    endtask

    // Sender: one transfer offered at a time, in bursts with gaps between them.
    always @(posedge i_clk) begin : drive
        t_console_key k;
        logic         busy;
        int           burst_left;
        int           gap_left;
        int           tx_mode;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
            burst_left = 1;
            gap_left   = 0;
        end else begin
            busy = i_s_tvalid && !o_s_tready;
            if (i_s_tvalid && o_s_tready) begin
                expected_results.push_back(decode_console_char(i_s_tdata[7:0], i_s_tdata[8]));
                keys_sent++;
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_keys.size() == 0 ||
                             (pending_keys[0].drain_first && expected_results.size() != 0)) begin
                    i_s_tvalid <= 1'b0;
                end else begin
                    k = pending_keys.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {7'd0, k.stopped, k.ch};
                    burst_left--;
                    if (burst_left <= 0) begin
                        tx_mode = (keys_sent / 400) % 3;
                        case (tx_mode)
                            0: begin
                                burst_left = $urandom_range(1, 12);
                                gap_left   = $urandom_range(0, 4);
                            end
                            1: begin
                                burst_left = 64;
                                gap_left   = 0;
                            end
                            default: begin
                                burst_left = $urandom_range(1, 3);
                                gap_left   = $urandom_range(3, 15);
                            end
                        endcase
                    end
                end
            end
        end
    end

    // Receiver: stall pattern, one long hold-off, and field checks on each transfer.
    always @(posedge i_clk) begin : watch
        t_result     want;
        t_result     got;
        int unsigned rx_tick;
        int          hold_left;
        bit          held_once;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            rx_tick   = 0;
            hold_left = 0;
            held_once = 0;
        end else begin
            rx_tick++;
            if (o_m_tvalid && i_m_tready) begin
                got.echo_valid      = o_m_tdata[0];
                got.echo_char       = o_m_tdata[8:1];
                got.breakpoint_set  = o_m_tdata[9];
                got.breakpoint_addr = o_m_tdata[25:10];
                got.pc_load         = o_m_tdata[26];
                got.pc_value        = o_m_tdata[42:27];
                got.mode_request    = t_mode'(o_m_tdata[44:43]);
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected: %h", o_m_tdata);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.echo_valid !== want.echo_valid) begin
                        $error("echo_valid expected %0d actual %0d",
                               want.echo_valid, got.echo_valid);
                        error_count++;
                    end
                    if (got.echo_char !== want.echo_char) begin
                        $error("echo_char expected %h actual %h", want.echo_char, got.echo_char);
                        error_count++;
                    end
                    if (got.breakpoint_set !== want.breakpoint_set) begin
                        $error("breakpoint_set expected %0d actual %0d",
                               want.breakpoint_set, got.breakpoint_set);
                        error_count++;
                    end
                    if (got.breakpoint_addr !== want.breakpoint_addr) begin
                        $error("breakpoint_addr expected %h actual %h",
                               want.breakpoint_addr, got.breakpoint_addr);
                        error_count++;
                    end
                    if (got.pc_load !== want.pc_load) begin
                        $error("pc_load expected %0d actual %0d", want.pc_load, got.pc_load);
                        error_count++;
                    end
                    if (got.pc_value !== want.pc_value) begin
                        $error("pc_value expected %h actual %h", want.pc_value, got.pc_value);
                        error_count++;
                    end
                    if (got.mode_request !== want.mode_request) begin
                        $error("mode_request expected %0d actual %0d",
                               want.mode_request, got.mode_request);
                        error_count++;
                    end
                end
            end
            // Long hold-off so the block fills up and drops its input ready.
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (!held_once && results_seen >= 300) begin
                held_once = 1;
                hold_left = 200;
                i_m_tready <= 1'b0;
            end else begin
                case ((results_seen / 350) % 4)
                    0: i_m_tready <= (rx_tick % 6) < 4;
                    1: i_m_tready <= 1'b1;
                    2: i_m_tready <= 1'($urandom_range(0, 1));
                    default: i_m_tready <= ((rx_tick / 16) % 3 != 0) && $urandom_range(0, 7) != 0;
                endcase
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int idx;
        clear_argument();

        // Directed keystrokes: extremes, every class and the special cases.
        put_text("7.", 1'b0);
        put_key(CH_ESC, 1'b1);
        put_key(8'h00, 1'b0);
        put_key(8'hFF, 1'b1);
        put_key(8'h38, 1'b1);
        put_key(CH_BANG, 1'b0);
        put_key(CH_BANG, 1'b1);
        put_key(CH_DOT, 1'b1);
        put_text("Y!", 1'b1);
        put_key(CH_AT, 1'b0);
        put_key(CH_Z, 1'b1);
        put_text("3 ", 1'b0);
        put_key(CH_NL, 1'b1);
        put_text("177777.", 1'b1);

        // Random commands, mostly well formed.
        idx = 0;
        while (queued_total < TOTAL_KEYS) begin
            put_command(idx);
            idx++;
        end

        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_keys.size() != 0 || i_s_tvalid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
